>>> sv/bpfa_pkg.sv
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared codes and widths for the bitmap page frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

   localparam int WORD_BITS = 32;
   localparam int BIT_W     = 5;
   localparam int TOTAL_W   = 17;

   localparam logic [WORD_BITS-1:0] FULL_WORD = '1;

   // request operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef logic [1:0] status_type;

   localparam status_type ST_DONE      = 2'd0;
   localparam status_type ST_NO_MEMORY = 2'd1;
   localparam status_type ST_RANGE     = 2'd2;

endpackage

>>> sv/bpfa_bitmap_ram.sv
// ----------------------------------------------------------------------------
// bpfa_bitmap_ram
// Single-port-write, single-port-read bitmap store with registered read data.
// ----------------------------------------------------------------------------
module bpfa_bitmap_ram
   import bpfa_pkg::*;
#(
   parameter int WORDS = 2048,
   parameter int AW    = 11
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   input  logic [AW-1:0]        rd_addr,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem [WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/bitmap_page_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// First-fit allocator of physical blocks over a bitmap of 32-bit words.
// ----------------------------------------------------------------------------
// After reset the block sweeps its bitmap memory once, one word a cycle,
// and holds busy high until the sweep is done; the first RESERVED_WORDS
// words come out all used. A free reads its bitmap word, then clears the
// bit and raises the result strobe from S_FREE; an address outside the
// managed range is answered from idle without a read. An allocate reads
// the bitmap from word 0 until a free block below the limit turns up: the
// scan reads one bitmap word a cycle through the single memory read port.
// Each result is shown for one cycle only on rsp_valid and cannot be held
// off; busy is low again in that same cycle. BLOCK_BYTES must be a power of
// two. csr_total_blocks is always ready and is meant to be written while
// the block is idle.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator
   import bpfa_pkg::*;
#(
   parameter int MAX_BLOCKS     = 65536,
   parameter int BLOCK_BYTES    = 4096,
   parameter int RESERVED_WORDS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_operation,
   input  logic [31:0]          req_address,
   output logic                 rsp_valid,
   output logic [31:0]          rsp_block_address,
   output logic [1:0]           rsp_status,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [TOTAL_W-1:0]   csr_total_blocks
);

   localparam int WORD_COUNT = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_W     = $clog2(WORD_COUNT);
   localparam int CNT_W      = WORD_W + 1;
   localparam int LIM_W      = $clog2(MAX_BLOCKS + 1);
   localparam int SHIFT      = $clog2(BLOCK_BYTES);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_FREE  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [CNT_W-1:0]     word_ff, word_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_addr_ff, rsp_addr_in;
   status_type           rsp_status_ff, rsp_status_in;

   logic                 wr_en;
   logic [WORD_W-1:0]    wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic [WORD_W-1:0]    rd_addr;
   logic [WORD_BITS-1:0] rd_data;

   logic [LIM_W-1:0]     limit;
   logic [31:0]          limit32;
   logic [31:0]          free_blk;
   logic [31:0]          base;
   logic [31:0]          remain;
   logic [WORD_BITS-1:0] mask;
   logic [WORD_BITS-1:0] avail;
   logic [BIT_W-1:0]     sel;
   logic [31:0]          found_blk;
   logic                 accept;

   bpfa_bitmap_ram #(
      .WORDS (WORD_COUNT),
      .AW    (WORD_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // saturate the register at MAX_BLOCKS
   always_comb begin
      if (32'(total_ff) > 32'(MAX_BLOCKS)) begin
         limit = LIM_W'(MAX_BLOCKS);
      end else begin
         limit = LIM_W'(total_ff);
      end
   end

   assign limit32  = 32'(limit);
   assign free_blk = req_address >> SHIFT;
   assign base     = 32'(word_ff) << BIT_W;
   assign remain   = limit32 - base;
   assign accept   = start && !busy;

   // keep only the bits of this word that lie below the limit
   always_comb begin
      if (remain >= 32'(WORD_BITS)) begin
         mask = FULL_WORD;
      end else begin
         mask = (WORD_BITS'(1) << remain[BIT_W-1:0]) - WORD_BITS'(1);
      end
   end

   assign avail = ~rd_data & mask;

   // lowest free bit wins
   always_comb begin
      sel = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (avail[i]) begin
            sel = BIT_W'(i);
         end
      end
   end

   assign found_blk = base | 32'(sel);

   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      bit_in        = bit_ff;
      total_in      = total_ff;
      rsp_valid_in  = 1'b0;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = word_ff[WORD_W-1:0];
      wr_data       = rd_data;
      rd_addr       = word_ff[WORD_W-1:0];

      if (csr_valid) begin
         total_in = csr_total_blocks;
      end

      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            if (32'(word_ff) < 32'(RESERVED_WORDS)) begin
               wr_data = FULL_WORD;
            end else begin
               wr_data = '0;
            end
            if (32'(word_ff) == 32'(WORD_COUNT - 1)) begin
               state_in = S_IDLE;
            end
            word_in = word_ff + CNT_W'(1);
         end
         S_IDLE: begin
            if (accept) begin
               if (req_operation == OP_ALLOC) begin
                  word_in  = '0;
                  rd_addr  = '0;
                  state_in = S_SCAN;
               end else if (free_blk >= limit32) begin
                  rsp_valid_in  = 1'b1;
                  rsp_addr_in   = '0;
                  rsp_status_in = ST_RANGE;
               end else begin
                  word_in  = CNT_W'(free_blk[WORD_W+BIT_W-1:BIT_W]);
                  bit_in   = free_blk[BIT_W-1:0];
                  rd_addr  = free_blk[WORD_W+BIT_W-1:BIT_W];
                  state_in = S_FREE;
               end
            end
         end
         S_SCAN: begin
            if (base >= limit32) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = ST_NO_MEMORY;
               state_in      = S_IDLE;
            end else if (avail != '0) begin
               wr_en         = 1'b1;
               wr_data       = rd_data | (WORD_BITS'(1) << sel);
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = found_blk << SHIFT;
               rsp_status_in = ST_DONE;
               state_in      = S_IDLE;
            end else begin
               // advance to the next word; its data lands next cycle
               word_in = word_ff + CNT_W'(1);
               rd_addr = word_in[WORD_W-1:0];
            end
         end
         S_FREE: begin
            wr_en         = 1'b1;
            wr_data       = rd_data & ~(WORD_BITS'(1) << bit_ff);
            rsp_valid_in  = 1'b1;
            rsp_addr_in   = '0;
            rsp_status_in = ST_DONE;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         word_ff      <= '0;
         total_ff     <= TOTAL_W'(65536);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff        <= bit_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

>>> dv/bpfa_checker.sv
// ----------------------------------------------------------------------------
// bpfa_checker
// Scoreboard for the bitmap page frame allocator.
// ----------------------------------------------------------------------------
// Watches the request, result and register channels. Every accepted request
// is run through a local first-fit model of the used bitmap, and the grant it
// produces is queued. Each result strobe is compared field by field with the
// oldest queued grant. The count of errors and the number of grants still
// owed are handed back to the testbench top.
// ----------------------------------------------------------------------------
module bpfa_checker
   import bpfa_pkg::*;
#(
   parameter int MAX_BLOCKS     = 65536,
   parameter int BLOCK_BYTES    = 4096,
   parameter int RESERVED_WORDS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic                 req_operation,
   input  logic [31:0]          req_address,
   input  logic                 rsp_valid,
   input  logic [31:0]          rsp_block_address,
   input  logic [1:0]           rsp_status,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [TOTAL_W-1:0]   csr_total_blocks,
   output int                   failures,
   output int                   pending
);

   localparam int WORD_COUNT = (MAX_BLOCKS + 31) / 32;

   typedef struct packed {
      logic [31:0] block_address;
      status_type  status;
   } grant_type;

   logic [WORD_BITS-1:0] used_words [WORD_COUNT];
   logic [TOTAL_W-1:0]   total_blocks_q;
   grant_type            grants_due[$];
   int                   error_total = 0;

   function automatic int unsigned managed_limit();
      if (total_blocks_q > MAX_BLOCKS) return MAX_BLOCKS;
      return total_blocks_q;
   endfunction

   task automatic clear_bitmap();
      int w;
      for (w = 0; w < WORD_COUNT; w++)
         used_words[w] = (w < RESERVED_WORDS) ? FULL_WORD : '0;
      total_blocks_q = 17'd65536;
   endtask

   // First-fit scan for an allocate, bit clear for a free.
   task automatic predict_grant(input logic op, input logic [31:0] addr,
                                output grant_type g);
      int unsigned     lim;
      int unsigned     blk;
      int              w;
      int              b;
      bit              found;
      longint unsigned byte_addr;
      lim             = managed_limit();
      g.block_address = '0;
      g.status        = ST_DONE;
      found           = 1'b0;
      if (op == OP_ALLOC) begin
         g.status = ST_NO_MEMORY;
         for (w = 0; w < WORD_COUNT && !found; w++) begin
            if (w * WORD_BITS >= lim) break;
            if (used_words[w] == FULL_WORD) continue;
            for (b = 0; b < WORD_BITS; b++) begin
               blk = w * WORD_BITS + b;
               if (blk >= lim) break;
               if (!used_words[w][b]) begin
                  used_words[w][b] = 1'b1;
                  byte_addr        = longint'(blk) * BLOCK_BYTES;
                  g.block_address  = byte_addr[31:0];
                  g.status         = ST_DONE;
                  found            = 1'b1;
                  break;
               end
            end
         end
      end else begin
         blk = addr / BLOCK_BYTES;
         if (blk >= lim)
            g.status = ST_RANGE;
         else
            used_words[blk / WORD_BITS][blk % WORD_BITS] = 1'b0;
      end
   endtask

   always @(posedge clock) begin : watch
      grant_type due;
      if (reset) begin
         clear_bitmap();
         grants_due.delete();
      end else begin
         // retire the result beat before queuing a request taken at the same edge
         if (rsp_valid) begin
            if (grants_due.size() == 0) begin
               $error("result without request: block_address %h status %0d",
                      rsp_block_address, rsp_status);
               error_total++;
            end else begin
               due = grants_due.pop_front();
               if (rsp_block_address !== due.block_address) begin
                  $error("block_address mismatch: expected %h, actual %h",
                         due.block_address, rsp_block_address);
                  error_total++;
               end
               if (rsp_status !== due.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         due.status, rsp_status);
                  error_total++;
               end
            end
         end
         if (csr_valid && csr_ready) total_blocks_q = csr_total_blocks;
         if (start && !busy) begin
            predict_grant(req_operation, req_address, due);
            grants_due.push_back(due);
         end
      end
      failures <= error_total;
      pending  <= grants_due.size();
   end

endmodule

>>> dv/bitmap_page_frame_allocator_tb.sv
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_tb
// Stimulus and verdict for the bitmap page frame allocator.
// ----------------------------------------------------------------------------
// After the post-reset sweep a directed sequence covers the first allocation,
// freeing of reserved and free blocks, addresses at and beyond the managed
// range, a saturated and a zero block count, and running out of memory.
// Random phases then mix allocates with frees aimed mostly at the allocated
// region, each under its own block count and one of three amounts of idling
// on the request side. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_tb;
   import bpfa_pkg::*;

   localparam int MAX_BLOCKS     = 65536;
   localparam int BLOCK_BYTES    = 4096;
   localparam int RESERVED_WORDS = 32;
   localparam int PHASE_ITEMS    = 240;
   localparam int CYCLE_LIMIT    = 20_000_000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_operation;
   logic [31:0]        req_address;
   logic               rsp_valid;
   logic [31:0]        rsp_block_address;
   logic [1:0]         rsp_status;
   logic               csr_valid;
   logic               csr_ready;
   logic [TOTAL_W-1:0] csr_total_blocks;
   int                 failures;
   int                 pending;
   int                 cycle_count = 0;

   int unsigned phase_totals [8] = '{65536, 1100, 131071, 0, 700, 3072, 65535, 1057};
   int          idle_pcts    [3] = '{0, 50, 31};

   bitmap_page_frame_allocator #(
      .MAX_BLOCKS     (MAX_BLOCKS),
      .BLOCK_BYTES    (BLOCK_BYTES),
      .RESERVED_WORDS (RESERVED_WORDS)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_address       (req_address),
      .rsp_valid         (rsp_valid),
      .rsp_block_address (rsp_block_address),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_total_blocks  (csr_total_blocks)
   );

   bpfa_checker #(
      .MAX_BLOCKS     (MAX_BLOCKS),
      .BLOCK_BYTES    (BLOCK_BYTES),
      .RESERVED_WORDS (RESERVED_WORDS)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_address       (req_address),
      .rsp_valid         (rsp_valid),
      .rsp_block_address (rsp_block_address),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_total_blocks  (csr_total_blocks),
      .failures          (failures),
      .pending           (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Hold the request until the block takes it; start stays high on return.
   task automatic issue_request(input logic op, input logic [31:0] addr);
      start         <= 1'b1;
      req_operation <= op;
      req_address   <= addr;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Drop start and wait for every owed result beat.
   task automatic drain_requests();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
   endtask

   task automatic set_total_blocks(input logic [TOTAL_W-1:0] value);
      drain_requests();
      csr_total_blocks <= value;
      csr_valid        <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int unsigned lim;
      int unsigned blk;
      int unsigned pick;
      logic        op;
      logic [31:0] addr;
      int          phase;
      int          n;
      int          idle_pct;

      reset            <= 1'b1;
      start            <= 1'b0;
      req_operation    <= OP_ALLOC;
      req_address      <= '0;
      csr_valid        <= 1'b0;
      csr_total_blocks <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // the bitmap sweep keeps busy high for a while
      while (busy) @(posedge clock);

      // directed: first grants, refree, reserved block, range edges
      issue_request(OP_ALLOC, 32'h0000_0000);
      issue_request(OP_ALLOC, 32'hFFFF_FFFF);
      issue_request(OP_FREE,  32'h0040_0ABC);
      issue_request(OP_ALLOC, 32'h0000_0000);
      issue_request(OP_FREE,  32'h0000_7123);
      issue_request(OP_ALLOC, 32'h0000_0000);
      issue_request(OP_FREE,  32'h0050_0000);
      issue_request(OP_FREE,  32'hFFFF_FFFF);
      issue_request(OP_FREE,  32'h0FFF_FFFF);
      issue_request(OP_FREE,  32'h1000_0000);
      // saturated count
      set_total_blocks(17'h1FFFF);
      issue_request(OP_FREE,  32'h1000_0000);
      issue_request(OP_FREE,  32'h0FFF_F000);
      issue_request(OP_ALLOC, 32'h0000_0000);
      // nothing managed
      set_total_blocks(17'd0);
      issue_request(OP_ALLOC, 32'h0000_0000);
      issue_request(OP_FREE,  32'h0000_0000);
      // one block, reserved until freed
      set_total_blocks(17'd1);
      issue_request(OP_ALLOC, 32'h0000_0000);
      issue_request(OP_FREE,  32'h0000_0FFF);
      issue_request(OP_ALLOC, 32'h0000_0000);
      issue_request(OP_ALLOC, 32'h0000_0000);
      // a few blocks past the reserved area, then out of memory
      set_total_blocks(17'd1030);
      repeat (6) issue_request(OP_ALLOC, $urandom);

      for (phase = 0; phase < 8; phase++) begin
         set_total_blocks(phase_totals[phase][TOTAL_W-1:0]);
         lim      = (phase_totals[phase] > MAX_BLOCKS) ? MAX_BLOCKS : phase_totals[phase];
         idle_pct = idle_pcts[phase % 3];
         for (n = 0; n < PHASE_ITEMS; n++) begin
            op   = ($urandom_range(0, 99) < 58) ? OP_ALLOC : OP_FREE;
            addr = $urandom;
            if (op == OP_FREE) begin
               pick = $urandom_range(0, 99);
               if (pick < 85) begin
                  // aim most frees at the allocated region or the managed range
                  if (pick < 45)      blk = $urandom_range(960, 2300);
                  else if (pick < 75) blk = $urandom_range(0, lim + 40);
                  else                blk = $urandom_range(0, 20'hFFFFF);
                  addr = blk * BLOCK_BYTES + $urandom_range(0, BLOCK_BYTES - 1);
               end
            end
            issue_request(op, addr);
            if ($urandom_range(0, 59) == 0) begin
               drain_requests();
            end else begin
               // idle the sender cycle by cycle at the phase's rate
               while ($urandom_range(0, 99) < idle_pct) begin
                  start <= 1'b0;
                  @(posedge clock);
               end
            end
         end
      end

      drain_requests();
      repeat (40) @(posedge clock);
      if (failures == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
